### hw/rtl/asm_operand_span_finder_unit_assert.svh
// Assertion macros for the operand span finder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASM_OPERAND_SPAN_FINDER_UNIT_ASSERT_SVH
`define ASM_OPERAND_SPAN_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASOF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/asof_pkg.sv
// Shared types and character constants for the operand span finder.
// No dependencies.
package asof_pkg;

    localparam int CHAR_W = 8;
    localparam int SPAN_W = 13;

    localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              empty_line;
    } char_item_t;

    typedef struct packed {
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
    } span_item_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_marker(input logic [CHAR_W-1:0] c);
        return (c == CH_SEMI) || (c == CH_HASH);
    endfunction

endpackage

### hw/rtl/asof_char_if.sv
// Character input channel: valid/ready handshake with one line byte.
// Depends on asof_pkg.
interface asof_char_if import asof_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic              empty_line;

    modport source (output valid, char_code, is_last, empty_line, input ready);
    modport sink   (input valid, char_code, is_last, empty_line, output ready);
endinterface

### hw/rtl/asof_span_if.sv
// Span result channel: valid/ready handshake with start and end offsets.
// Depends on asof_pkg.
interface asof_span_if import asof_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;

    modport source (output valid, span_start, span_end, input ready);
    modport sink   (input valid, span_start, span_end, output ready);
endinterface

### hw/rtl/asm_operand_span_finder_unit.sv
// Operand span finder: a line's closing character passes the input register, then
// the scan logic into the result register that drives span valid.
// Throughput 1 character per cycle unless a span held in the result register stalls the input.
// Reset (rst_n low, asynchronous) empties both registers and returns the scan
// state to the start of a line.
// Depends on asof_pkg, asof_char_if, asof_span_if and the stage modules.
`include "asm_operand_span_finder_unit_assert.svh"

module asm_operand_span_finder_unit import asof_pkg::*;
#(
    parameter int MAX_LINE = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    asof_char_if.sink   char_in,
    asof_span_if.source span_out
);

    logic       stage_valid;
    char_item_t stage_item;
    logic       can_take;
    logic       advance;
    logic       res_valid;
    span_item_t res_span;

    assign advance = stage_valid && can_take;

    asof_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    asof_scan #(
        .MAX_LINE (MAX_LINE)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (stage_item),
        .res_valid (res_valid),
        .res_span  (res_span)
    );

    asof_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_span  (res_span),
        .can_take  (can_take),
        .span_out  (span_out)
    );

    `ASOF_ASSERT_NEXT(a_result_lands, res_valid, span_out.valid, "span result lost")
    `ASOF_ASSERT_NEXT(a_stage_holds, stage_valid && !advance, stage_valid,
                      "input stage dropped a held character")
    `ASOF_ASSERT_SAME(a_stall_means_full, !char_in.ready, stage_valid && !can_take,
                      "input stalled without a blocked stage")

endmodule

### hw/rtl/asof_in_stage.sv
// Input register for the character channel.
// Depends on asof_pkg and asof_char_if.
module asof_in_stage import asof_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    asof_char_if.sink   char_in,
    input  logic        advance,
    output logic        stage_valid,
    output char_item_t  stage_item
);

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       take;

    assign char_in.ready = !valid_reg || advance;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{char_code:  char_in.char_code,
                          is_last:    char_in.is_last,
                          empty_line: char_in.empty_line};
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

### hw/rtl/asof_scan.sv
// Line scan state and per-character update; produces the span on the last byte or an empty-line item.
// Depends on asof_pkg.
module asof_scan import asof_pkg::*;
#(
    parameter int MAX_LINE = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  char_item_t item,
    output logic       res_valid,
    output span_item_t res_span
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LINE);

    typedef struct packed {
        logic [PW-1:0] char_pos;
        logic          word_begun;
        logic          word_finished;
        logic          in_trail;
        logic [PW-1:0] cut_pos;
        logic          cut_eol;
        logic [PW-1:0] op_start;
        logic          pend;
        logic [PW-1:0] pend_pos;
        logic          comment;
    } scan_state_t;

    localparam scan_state_t STATE_RST = '{
        char_pos:      '0,
        word_begun:    1'b0,
        word_finished: 1'b0,
        in_trail:      1'b0,
        cut_pos:       '0,
        cut_eol:       1'b1,
        op_start:      '0,
        pend:          1'b0,
        pend_pos:      '0,
        comment:       1'b0
    };

    function automatic logic [SPAN_W-1:0] to_span(input logic [PW-1:0] v);
        logic [PW+SPAN_W-1:0] w;
        w = {{SPAN_W{1'b0}}, v};
        return w[SPAN_W-1:0];
    endfunction

    scan_state_t st_reg;
    scan_state_t st_next;

    always_comb
    begin
        scan_state_t   s;
        logic          blank;
        logic          letter;
        logic          marker;
        logic          done;
        logic          open_en;
        logic [PW-1:0] open_pos;
        logic [PW-1:0] p;
        logic [PW-1:0] pos_next;
        logic [PW-1:0] end_pos;

        s        = st_reg;
        p        = st_reg.char_pos;
        blank    = is_blank(item.char_code);
        letter   = is_letter(item.char_code);
        marker   = is_marker(item.char_code);
        done     = 1'b0;
        open_en  = 1'b0;
        open_pos = p;

        if (!s.comment)
        begin
            if (s.pend)
            begin
                if (blank)
                begin
                    open_en  = 1'b1;
                    open_pos = s.pend_pos;
                    done     = 1'b1;
                end
                else
                begin
                    s.pend = 1'b0;
                end
            end
            if (!done)
            begin
                if (marker)
                begin
                    if (item.is_last)
                    begin
                        open_en  = 1'b1;
                        open_pos = p;
                    end
                    else
                    begin
                        s.pend     = 1'b1;
                        s.pend_pos = p;
                    end
                end
                else if (!s.word_begun && letter)
                begin
                    s.word_begun = 1'b1;
                end
                else if (s.word_begun && !s.word_finished && blank)
                begin
                    s.word_finished = 1'b1;
                    s.op_start      = p;
                end
                else if (s.word_finished)
                begin
                    if (s.in_trail)
                    begin
                        if (!blank)
                        begin
                            s.cut_eol  = 1'b1;
                            s.in_trail = 1'b0;
                        end
                    end
                    else if (blank)
                    begin
                        s.in_trail = 1'b1;
                        s.cut_pos  = p;
                        s.cut_eol  = 1'b0;
                    end
                end
            end
        end

        if (open_en)
        begin
            if (!s.in_trail)
            begin
                s.cut_pos = open_pos;
                s.cut_eol = 1'b0;
            end
            s.comment = 1'b1;
            s.pend    = 1'b0;
        end

        pos_next   = (p < POS_MAX) ? p + PW'(1) : POS_MAX;
        s.char_pos = pos_next;
        end_pos    = s.cut_eol ? pos_next : s.cut_pos;

        res_valid = fire && (item.empty_line || item.is_last);
        if (item.empty_line)
        begin
            res_span = '{span_start: '0, span_end: '0};
        end
        else
        begin
            res_span = '{span_start: to_span(s.op_start), span_end: to_span(end_pos)};
        end

        st_next = st_reg;
        if (fire)
        begin
            st_next = (item.empty_line || item.is_last) ? STATE_RST : s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STATE_RST;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

### hw/rtl/asof_out_stage.sv
// Result register for the span channel.
// Depends on asof_pkg and asof_span_if.
module asof_out_stage import asof_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  span_item_t  res_span,
    output logic        can_take,
    asof_span_if.source span_out
);

    logic       valid_reg;
    logic       valid_next;
    span_item_t span_reg;

    assign can_take = !valid_reg || span_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (span_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            span_reg <= res_span;
        end
    end

    assign span_out.valid      = valid_reg;
    assign span_out.span_start = span_reg.span_start;
    assign span_out.span_end   = span_reg.span_end;

endmodule

### bench/testbench.sv
// Testbench for asm_operand_span_finder_unit: walks a directed line table, then random lines
// under several handshake mixes, and checks each span against a built-in scanner model or, for typed rows, the table.
// Depends on asof_pkg, asof_char_if, asof_span_if and the RTL top level.
`timescale 1ns / 1ps

module testbench import asof_pkg::*;
    ;

    localparam int LINE_LIMIT   = 4096;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_CHARS  = 80;
    localparam int PRESS_CHARS  = 40;
    localparam int PLAN_ROWS    = 34;

    typedef struct packed {
        logic [SPAN_W-1:0] pos;
        logic              word_started;
        logic              word_done;
        logic              in_blank_run;
        logic [SPAN_W-1:0] cut;
        logic              cut_is_eol;
        logic [SPAN_W-1:0] operand_at;
        logic              marker_held;
        logic [SPAN_W-1:0] marker_at;
        logic              comment_seen;
    } scan_state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        int                count;
        logic              last;
        logic              empty;
        logic              typed;
        logic [SPAN_W-1:0] want_start;
        logic [SPAN_W-1:0] want_end;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{8'h00,      1,    1, 1, 1, 13'd0,    13'd0},
        '{CH_TAB,     1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_UPPER_Z, 1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SPACE,   1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_HASH,    1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h78,      1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SPACE,   2,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SEMI,    1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_TAB,     1,    0, 0, 0, 13'd0,    13'd0},
        '{8'hFF,      1,    1, 0, 0, 13'd0,    13'd0},
        '{8'h00,      1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h80,      1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_LOWER_A, 1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_TAB,     1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h31,      1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SEMI,    1,    1, 0, 0, 13'd0,    13'd0},
        '{8'h6D,      1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SPACE,   1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_HASH,    1,    0, 0, 0, 13'd0,    13'd0},
        '{8'hA5,      1,    1, 1, 1, 13'd0,    13'd0},
        '{CH_UPPER_A, 1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_LOWER_Z, 1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SPACE,   1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SEMI,    1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_HASH,    1,    0, 0, 0, 13'd0,    13'd0},
        '{CH_SPACE,   1,    1, 0, 0, 13'd0,    13'd0},
        '{CH_LOWER_A, 60,   0, 0, 0, 13'd0,    13'd0},
        '{CH_SPACE,   1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h78,      1,    1, 0, 0, 13'd0,    13'd0},
        '{8'h40,      1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h5B,      1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h60,      1,    0, 0, 0, 13'd0,    13'd0},
        '{8'h7B,      1,    1, 0, 0, 13'd0,    13'd0},
        '{8'h71,      1,    1, 0, 0, 13'd0,    13'd0}
    };

    logic clk;
    logic rst_n;

    asof_char_if char_in ();
    asof_span_if span_out ();

    asm_operand_span_finder_unit #(
        .MAX_LINE(LINE_LIMIT)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .span_out(span_out)
    );

    scan_state_t scan;
    span_item_t  span_q[$];
    int          fails;
    int          chars_sent;
    int          spans_checked;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_asks;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_scan();
        scan = '0;
        scan.cut_is_eol = 1'b1;
    endfunction

    function automatic void take_comment(input logic [SPAN_W-1:0] at);
        if (!scan.in_blank_run)
        begin
            scan.cut        = at;
            scan.cut_is_eol = 1'b0;
        end
        scan.comment_seen = 1'b1;
        scan.marker_held  = 1'b0;
    endfunction

    function automatic bit scan_char(input char_item_t it, output span_item_t span);
        logic [CHAR_W-1:0] c;
        logic [SPAN_W-1:0] p;
        logic              blank;
        logic              letter;
        logic              handled;
        c       = it.char_code;
        p       = scan.pos;
        blank   = (c == CH_SPACE) || (c == CH_TAB);
        letter  = ((c | 8'h20) >= CH_LOWER_A) && ((c | 8'h20) <= CH_LOWER_Z);
        handled = 1'b0;
        span    = '0;
        if (it.empty_line)
        begin
            clear_scan();
            return 1'b1;
        end
        if (!scan.comment_seen)
        begin
            if (scan.marker_held)
            begin
                scan.marker_held = 1'b0;
                if (blank)
                begin
                    take_comment(scan.marker_at);
                    handled = 1'b1;
                end
            end
            if (!handled)
            begin
                if (c == CH_SEMI || c == CH_HASH)
                begin
                    if (it.is_last)
                        take_comment(p);
                    else
                    begin
                        scan.marker_held = 1'b1;
                        scan.marker_at   = p;
                    end
                end
                else if (!scan.word_started && letter)
                    scan.word_started = 1'b1;
                else if (scan.word_started && !scan.word_done && blank)
                begin
                    scan.word_done  = 1'b1;
                    scan.operand_at = p;
                end
                else if (scan.word_done)
                begin
                    if (scan.in_blank_run)
                    begin
                        if (!blank)
                        begin
                            scan.cut_is_eol   = 1'b1;
                            scan.in_blank_run = 1'b0;
                        end
                    end
                    else if (blank)
                    begin
                        scan.in_blank_run = 1'b1;
                        scan.cut          = p;
                        scan.cut_is_eol   = 1'b0;
                    end
                end
            end
        end
        scan.pos = (p < LINE_LIMIT) ? p + 1'b1 : SPAN_W'(LINE_LIMIT);
        if (!it.is_last)
            return 1'b0;
        span.span_start = scan.operand_at;
        span.span_end   = scan.cut_is_eol ? scan.pos : scan.cut;
        clear_scan();
        return 1'b1;
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [CHAR_W-1:0] letter_char();
        return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + CHAR_W'($urandom_range(25));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(9))
            0, 1:    return letter_char();
            2:       return 8'h30 + CHAR_W'($urandom_range(9));
            3:       return blank_char();
            4:       return $urandom_range(1) ? CH_SEMI : CH_HASH;
            5:       return 8'h2C;
            6, 7:    return CHAR_W'($urandom_range(255));
            default: return CHAR_W'($urandom_range(8'h7E, 8'h21));
        endcase
    endfunction

    task automatic send_char(input char_item_t it, input bit typed, input span_item_t typed_span);
        span_item_t span;
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_in.valid <= 1'b0;
            @(posedge clk);
        end
        char_in.valid      <= 1'b1;
        char_in.char_code  <= it.char_code;
        char_in.is_last    <= it.is_last;
        char_in.empty_line <= it.empty_line;
        do
            @(posedge clk);
        while (!char_in.ready);
        if (scan_char(it, span))
            span_q = {span_q, (typed ? typed_span : span)};
        chars_sent++;
    endtask

    task automatic send_line(input bit short_only);
        logic [CHAR_W-1:0] text[$];
        char_item_t        it;
        int                kind;
        kind = $urandom_range(19);
        if (kind == 0)
        begin
            it.char_code  = CHAR_W'($urandom_range(255));
            it.is_last    = 1'($urandom_range(1));
            it.empty_line = 1'b1;
            send_char(it, 1'b0, '0);
            return;
        end
        if (short_only)
            repeat ($urandom_range(2, 1)) text = {text, pick_char()};
        else if (kind <= 3)
            repeat ($urandom_range(10, 1)) text = {text, pick_char()};
        else
        begin
            repeat ($urandom_range(2)) text = {text, blank_char()};
            repeat ($urandom_range(5, 1)) text = {text, letter_char()};
            repeat ($urandom_range(2, 1)) text = {text, blank_char()};
            repeat ($urandom_range(3))
            begin
                repeat ($urandom_range(4, 1)) text = {text, pick_char()};
                text = {text, ($urandom_range(1) ? 8'h2C : blank_char())};
            end
            if ($urandom_range(2) == 0)
            begin
                text = {text, ($urandom_range(1) ? CH_SEMI : CH_HASH)};
                if ($urandom_range(3) != 0)
                    text = {text, blank_char()};
                repeat ($urandom_range(4)) text = {text, pick_char()};
            end
            repeat ($urandom_range(2)) text = {text, blank_char()};
        end
        for (int i = 0; i < text.size(); i++)
        begin
            it.char_code  = text[i];
            it.is_last    = (i == text.size() - 1);
            it.empty_line = 1'b0;
            if (kind == 4 && !short_only && i == text.size() / 2)
            begin
                it.empty_line = 1'b1;
                it.is_last    = 1'($urandom_range(1));
                send_char(it, 1'b0, '0);
                return;
            end
            send_char(it, 1'b0, '0);
        end
    endtask

    task automatic check_span(input logic [SPAN_W-1:0] got_start, input logic [SPAN_W-1:0] got_end);
        span_item_t want;
        if (span_q.size() == 0)
        begin
            $error("unexpected span transfer: span_start %0d span_end %0d", got_start, got_end);
            fails++;
            return;
        end
        want = span_q.pop_front();
        spans_checked++;
        if (got_start !== want.span_start)
        begin
            $error("span_start: expected %0d, actual %0d", want.span_start, got_start);
            fails++;
        end
        if (got_end !== want.span_end)
        begin
            $error("span_end: expected %0d, actual %0d", want.span_end, got_end);
            fails++;
        end
    endtask

    initial
    begin : span_sink
        int hold_left;
        int holds_seen;
        hold_left      = 0;
        holds_seen     = 0;
        span_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && span_out.valid && span_out.ready)
                check_span(span_out.span_start, span_out.span_end);
            if (hold_left > 0)
            begin
                hold_left--;
                span_out.ready <= 1'b0;
            end
            else if (holds_seen != hold_asks)
            begin
                holds_seen     = hold_asks;
                hold_left      = HOLD_CYCLES;
                span_out.ready <= 1'b0;
            end
            else
                span_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_in.valid && char_in.ready) || (span_out.valid && span_out.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        char_item_t it;
        span_item_t typed_span;
        int         target;
        rst_n              = 1'b0;
        char_in.valid      = 1'b0;
        char_in.char_code  = '0;
        char_in.is_last    = 1'b0;
        char_in.empty_line = 1'b0;
        fails              = 0;
        chars_sent         = 0;
        spans_checked      = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_asks          = 0;
        clear_scan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            for (int k = 0; k < PLAN[r].count; k++)
            begin
                it.char_code          = PLAN[r].code;
                it.is_last            = PLAN[r].last && (k == PLAN[r].count - 1);
                it.empty_line         = PLAN[r].empty;
                typed_span.span_start = PLAN[r].want_start;
                typed_span.span_end   = PLAN[r].want_end;
                send_char(it, PLAN[r].typed && (k == PLAN[r].count - 1), typed_span);
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target)
                send_line(1'b0);
        end

        // stall the output while short lines keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks++;
        target = chars_sent + PRESS_CHARS;
        while (chars_sent < target)
            send_line(1'b1);
        char_in.valid <= 1'b0;

        while (span_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d spans over %0d characters: directed lines incl. a long line,",
                 spans_checked, chars_sent);
        $display("random lines under four handshake mixes and a %0d-cycle output hold.", HOLD_CYCLES);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/asof_pkg.sv
hw/rtl/asof_char_if.sv
hw/rtl/asof_span_if.sv
hw/rtl/asof_in_stage.sv
hw/rtl/asof_scan.sv
hw/rtl/asof_out_stage.sv
hw/rtl/asm_operand_span_finder_unit.sv
bench/testbench.sv
